// ----- hdl/vifc_pkg.sv -----
// shared types, constants and helpers for the velocity integrator block
// no dependencies
package vifc_pkg;

  localparam int FRAC_BITS = 16;
  localparam int STEPS = 32;
  localparam int CNT_W = $clog2(STEPS);
  localparam int WIDE_W = 49;
  localparam logic [31:0] STOP_THRESH = 32'((((64'd1 << FRAC_BITS) * 2) + 5) / 10);

  typedef enum logic [2:0] {
    CMD_TICK      = 3'd0,
    CMD_ACCEL     = 3'd1,
    CMD_OVR_ACCEL = 3'd2,
    CMD_SET_SPEED = 3'd3,
    CMD_OVR_SPEED = 3'd4,
    CMD_IMMOBILE  = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    REG_MODE  = 2'd0,
    REG_MACC  = 2'd1,
    REG_MSPD  = 2'd2
  } reg_e;

  typedef struct packed {
    logic mul_en;
    logic div_start;
  } lane_ctl_t;

  function automatic logic [31:0] abs32(input logic [31:0] v);
    return v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [31:0] sat32(input logic signed [WIDE_W-1:0] v);
    logic signed [WIDE_W-1:0] hi;
    logic signed [WIDE_W-1:0] lo;
    hi = WIDE_W'(32'sh7fffffff);
    lo = -(WIDE_W'(64'sh80000000));
    if (v > hi) return 32'h7fffffff;
    if (v < lo) return 32'h80000000;
    return v[31:0];
  endfunction

endpackage

// ----- hdl/vifc_lane.sv -----
// one component lane: registered 32x32 multiplier and radix-2 divider
// depends on vifc_pkg
module vifc_lane (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  vifc_pkg::lane_ctl_t ctl_i,
  input  logic [31:0]         op_a_i,
  input  logic [31:0]         op_b_i,
  input  logic [31:0]         divisor_i,
  output logic [63:0]         prod_o,
  output logic [31:0]         quot_o,
  output logic                div_done_o
);
  import vifc_pkg::*;

  logic [63:0]      prod_q;
  logic [31:0]      rem_q, dvd_q;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;
  logic [32:0]      trial;
  logic             ge;

  assign trial = {rem_q, dvd_q[31]};
  assign ge    = trial >= {1'b0, divisor_i};

  always_ff @(posedge clk_i) begin
    if (ctl_i.mul_en) begin
      prod_q <= 64'(op_a_i) * 64'(op_b_i);
    end
  end

  // quotient fits 32 bits, so the upper product half starts as remainder
  always_ff @(posedge clk_i) begin
    if (ctl_i.div_start) begin
      rem_q <= prod_q[63:32];
      dvd_q <= prod_q[31:0];
    end else if (busy_q) begin
      rem_q <= ge ? 32'(trial - {1'b0, divisor_i}) : trial[31:0];
      dvd_q <= {dvd_q[30:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.div_start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign prod_o     = prod_q;
  assign quot_o     = dvd_q;
  assign div_done_o = done_q;

endmodule

// ----- hdl/vifc_norm.sv -----
// merging stage: sums the lane squares and takes an iterative square root
// depends on vifc_pkg
module vifc_norm (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] sq0_i,
  input  logic [63:0] sq1_i,
  input  logic [63:0] sq2_i,
  output logic [31:0] root_o,
  output logic        done_o
);
  import vifc_pkg::*;

  logic [63:0]      acc_q, r_q, bit_q;
  logic [63:0]      t;
  logic [CNT_W-1:0] cnt_q;
  logic             busy_q, done_q;

  assign t = r_q + bit_q;

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= sq0_i + sq1_i + sq2_i;
      r_q   <= '0;
      bit_q <= 64'd1 << 62;
    end else if (busy_q) begin
      if (acc_q >= t) begin
        acc_q <= acc_q - t;
        r_q   <= (r_q >> 1) + bit_q;
      end else begin
        r_q <= r_q >> 1;
      end
      bit_q <= bit_q >> 2;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign root_o = r_q[31:0];
  assign done_o = done_q;

endmodule

// ----- hdl/velocity_integrator_friction_clamp_top.sv -----
// top level: apb registers, command sequencer, three lanes and the norm unit
// depends on vifc_pkg, vifc_lane, vifc_norm
//
// usage
//   input channel carries one command with a vector and an elapsed time;
//   a transfer happens when in_valid_i is high and in_stall_o is low
//   every command gives exactly one result transfer with velocity and
//   acceleration after the step; the result is held until out_stall_i is low
//   one command is worked at a time; in_stall_o stays high until its result
//   has been taken
//   for overrides, immobilize, unused codes and fixed-mode ticks the result
//   is offered in the cycle after the command transfer; direction commands
//   work the squares and the 32-step square root, then the scale multiply
//   and the 32-step divide, then give the result
//   a variable-mode tick runs at most these passes in order: integrate,
//   friction scale, norm check, clamp scale, stop norm, result
//   the user is to write the registers (speed_mode, max_acceleration, max_speed)
//   over apb at byte addresses 0, 4, 8 only while the block is idle; the block
//   itself does not enforce it; pready is always high
//   reset clears both vectors, the registers and the sequencer
module velocity_integrator_friction_clamp_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // command channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [2:0]  command_i,
  input  logic [31:0] vec_x_i,
  input  logic [31:0] vec_y_i,
  input  logic [31:0] vec_z_i,
  input  logic [23:0] elapsed_i,
  // result channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] speed_x_o,
  output logic [31:0] speed_y_o,
  output logic [31:0] speed_z_o,
  output logic [31:0] accel_x_o,
  output logic [31:0] accel_y_o,
  output logic [31:0] accel_z_o
);
  import vifc_pkg::*;

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_ACCM  = 11'b00000000010,
    S_ACCA  = 11'b00000000100,
    S_SQ    = 11'b00000001000,
    S_NST   = 11'b00000010000,
    S_NRM   = 11'b00000100000,
    S_MULS  = 11'b00001000000,
    S_DST   = 11'b00010000000,
    S_DIV   = 11'b00100000000,
    S_APPLY = 11'b01000000000,
    S_OUT   = 11'b10000000000
  } state_e;

  // what the current norm or scale pass is for
  typedef enum logic [2:0] {
    PH_CACC = 3'd0,
    PH_CVEL = 3'd1,
    PH_FRIC = 3'd2,
    PH_CCHK = 3'd3,
    PH_CLMP = 3'd4,
    PH_STOP = 3'd5
  } phase_e;

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic        mode_q;
  logic [30:0] macc_q, mspd_q, mag_q, mag_d;
  logic [31:0] vel_q [3];
  logic [31:0] vel_d [3];
  logic [31:0] acc_q [3];
  logic [31:0] acc_d [3];
  logic [31:0] src_q [3];
  logic [31:0] src_d [3];
  logic [23:0] el_q, el_d;
  logic [31:0] n_q, n_d;
  logic        zero_q, zero_d;

  lane_ctl_t   ctl;
  logic [31:0] sel   [3];
  logic [31:0] op_a  [3];
  logic [31:0] op_b  [3];
  logic [63:0] prod  [3];
  logic [31:0] quot  [3];
  logic [31:0] q_s   [3];
  logic        ldone [3];
  logic [31:0] root;
  logic        ndone;
  logic        in_xfer, cfg_wr, acc_zero;

  assign in_xfer  = in_valid_i && !in_stall_o;
  assign cfg_wr   = psel && penable && pwrite && pready;
  assign acc_zero = (acc_q[0] == '0) && (acc_q[1] == '0) && (acc_q[2] == '0);

  // apb registers
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= 1'b0;
      macc_q <= '0;
      mspd_q <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_MODE: mode_q <= pwdata[0];
        REG_MACC: macc_q <= pwdata[30:0];
        REG_MSPD: mspd_q <= pwdata[30:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_MODE: prdata = {31'b0, mode_q};
      REG_MACC: prdata = {1'b0, macc_q};
      REG_MSPD: prdata = {1'b0, mspd_q};
      default:  prdata = '0;
    endcase
  end

  // lanes: one per vector component
  assign ctl.mul_en    = (state_q == S_ACCM) || (state_q == S_SQ) || (state_q == S_MULS);
  assign ctl.div_start = (state_q == S_DST);

  for (genvar i = 0; i < 3; i++) begin : g_lane
    assign sel[i] = ((phase_q == PH_CACC) || (phase_q == PH_CVEL)) ? src_q[i] : vel_q[i];
    always_comb begin
      op_a[i] = abs32(sel[i]);
      op_b[i] = abs32(sel[i]);
      if (state_q == S_ACCM) begin
        op_a[i] = abs32(acc_q[i]);
        op_b[i] = {8'b0, el_q};
      end else if (state_q == S_MULS) begin
        op_b[i] = {1'b0, mag_q};
      end
    end
    // scaled component carries the sign of its source
    assign q_s[i] = zero_q ? '0 : (sel[i][31] ? (~quot[i] + 32'd1) : quot[i]);

    vifc_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .ctl_i      (ctl),
      .op_a_i     (op_a[i]),
      .op_b_i     (op_b[i]),
      .divisor_i  (n_q),
      .prod_o     (prod[i]),
      .quot_o     (quot[i]),
      .div_done_o (ldone[i])
    );
  end

  vifc_norm u_norm (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (state_q == S_NST),
    .sq0_i   (prod[0]),
    .sq1_i   (prod[1]),
    .sq2_i   (prod[2]),
    .root_o  (root),
    .done_o  (ndone)
  );

  // sequencer
  always_comb begin
    logic [WIDE_W-1:0]        dmag;
    logic signed [WIDE_W-1:0] dsig;
    state_d = state_q;
    phase_d = phase_q;
    mag_d   = mag_q;
    el_d    = el_q;
    n_d     = n_q;
    zero_d  = zero_q;
    vel_d   = vel_q;
    acc_d   = acc_q;
    src_d   = src_q;
    dmag    = '0;
    dsig    = '0;
    case (state_q)
      S_IDLE: begin
        if (in_xfer) begin
          el_d     = elapsed_i;
          src_d[0] = vec_x_i;
          src_d[1] = vec_y_i;
          src_d[2] = vec_z_i;
          state_d  = S_OUT;
          case (command_i)
            CMD_TICK: begin
              if (mode_q) state_d = S_ACCM;
            end
            CMD_ACCEL: begin
              mag_d   = macc_q;
              phase_d = PH_CACC;
              state_d = S_SQ;
            end
            CMD_OVR_ACCEL: begin
              acc_d[0] = vec_x_i;
              acc_d[1] = vec_y_i;
              acc_d[2] = vec_z_i;
            end
            CMD_SET_SPEED: begin
              mag_d   = mspd_q;
              phase_d = PH_CVEL;
              state_d = S_SQ;
            end
            CMD_OVR_SPEED: begin
              vel_d[0] = vec_x_i;
              vel_d[1] = vec_y_i;
              vel_d[2] = vec_z_i;
            end
            CMD_IMMOBILE: begin
              for (int i = 0; i < 3; i++) begin
                vel_d[i] = '0;
                acc_d[i] = '0;
              end
            end
            default: ;
          endcase
        end
      end
      S_ACCM: state_d = S_ACCA;
      S_ACCA: begin
        // integrate acceleration times elapsed, then friction pass
        for (int i = 0; i < 3; i++) begin
          dmag     = WIDE_W'(prod[i] >> FRAC_BITS);
          dsig     = acc_q[i][31] ? -$signed(dmag) : $signed(dmag);
          vel_d[i] = sat32($signed(WIDE_W'($signed(vel_q[i]))) + dsig);
        end
        mag_d   = 31'(el_q >> 1);
        phase_d = PH_FRIC;
        state_d = S_SQ;
      end
      S_SQ:  state_d = S_NST;
      S_NST: state_d = S_NRM;
      S_NRM: begin
        if (ndone) begin
          n_d    = root;
          zero_d = (root == '0);
          case (phase_q)
            PH_CCHK: begin
              if (root >= {1'b0, mspd_q}) begin
                mag_d   = mspd_q;
                phase_d = PH_CLMP;
                state_d = (root == '0) ? S_APPLY : S_MULS;
              end else if (acc_zero) begin
                phase_d = PH_STOP;
                state_d = S_SQ;
              end else begin
                state_d = S_OUT;
              end
            end
            PH_STOP: begin
              if (root < STOP_THRESH) begin
                for (int i = 0; i < 3; i++) vel_d[i] = '0;
              end
              state_d = S_OUT;
            end
            default: state_d = (root == '0) ? S_APPLY : S_MULS;
          endcase
        end
      end
      S_MULS: state_d = S_DST;
      S_DST:  state_d = S_DIV;
      S_DIV:  if (ldone[0] && ldone[1] && ldone[2]) state_d = S_APPLY;
      S_APPLY: begin
        case (phase_q)
          PH_CACC: begin
            acc_d   = q_s;
            state_d = S_OUT;
          end
          PH_CVEL: begin
            vel_d   = q_s;
            state_d = S_OUT;
          end
          PH_FRIC: begin
            for (int i = 0; i < 3; i++) begin
              vel_d[i] = sat32($signed(WIDE_W'($signed(vel_q[i])))
                               - $signed(WIDE_W'($signed(q_s[i]))));
            end
            phase_d = PH_CCHK;
            state_d = S_SQ;
          end
          default: begin
            // clamp result, then the stop test when there is no acceleration
            vel_d = q_s;
            if (acc_zero) begin
              phase_d = PH_STOP;
              state_d = S_SQ;
            end else begin
              state_d = S_OUT;
            end
          end
        endcase
      end
      S_OUT:   if (!out_stall_i) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_CACC;
      for (int i = 0; i < 3; i++) begin
        vel_q[i] <= '0;
        acc_q[i] <= '0;
      end
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      vel_q   <= vel_d;
      acc_q   <= acc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    src_q  <= src_d;
    mag_q  <= mag_d;
    el_q   <= el_d;
    n_q    <= n_d;
    zero_q <= zero_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign speed_x_o   = vel_q[0];
  assign speed_y_o   = vel_q[1];
  assign speed_z_o   = vel_q[2];
  assign accel_x_o   = acc_q[0];
  assign accel_y_o   = acc_q[1];
  assign accel_z_o   = acc_q[2];

  // a pending result blocks new commands
  a_out_blocks_in: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("command taken while result pending");

  // immobilize clears both vectors
  a_immobile: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && command_i == CMD_IMMOBILE) |=>
      (vel_q[0] == '0 && vel_q[1] == '0 && vel_q[2] == '0 && acc_zero))
    else $error("immobilize left a nonzero vector");

  // the square root only completes while the sequencer waits for it
  a_norm_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ndone |-> (state_q == S_NRM))
    else $error("norm finished outside its wait state");

endmodule
